### sv/gregorian_to_solar_hijri_date_core_macros.svh
// Assertion macros used by the date converter core.
// Each use is written on a line of its own; the macro supplies the semicolon.
`ifndef GREGORIAN_TO_SOLAR_HIJRI_DATE_CORE_MACROS_SVH
`define GREGORIAN_TO_SOLAR_HIJRI_DATE_CORE_MACROS_SVH
`ifndef SYNTH
// Property checked at every clock edge, switched off while reset is high.
`define G2SH_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Property checked at every clock edge, including during reset.
`define G2SH_ASSERT_NR(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define G2SH_ASSERT(label, clk_s, rst_s, prop, msg)
`define G2SH_ASSERT_NR(label, clk_s, prop, msg)
`endif
`endif

### sv/g2sh_pkg.sv
package g2sh_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int LEN_W   = 5;

  // Width of the absolute day count and of the intermediate remainders.
  localparam int DAYS_W  = 21;
  localparam int REM33_W = 14;
  localparam int REM4_W  = 11;
  localparam int DOY_W   = 9;

  localparam int MONTHS          = 12;
  localparam int MONTH_FEB       = 2;
  localparam int DAY_BASE        = 355666;
  localparam int CYCLE33_DAYS    = 12053;
  localparam int CYCLE33_YEARS   = 33;
  localparam int GROUP4_DAYS     = 1461;
  localparam int GROUP4_YEARS    = 4;
  localparam int YEAR_DAYS       = 365;
  localparam int YEAR_BASE       = -1595;
  localparam int FIRST_HALF_DAYS = 186;
  localparam int LONG_MONTH      = 31;
  localparam int SHORT_MONTH     = 30;
  localparam int HALF_MONTHS     = 6;

  // Reciprocals for division by constants: q = (x * RECIP) >> SHIFT.
  // The 100, 400 and 1461 forms are exact over their input ranges; the
  // 12053 form may come out one low and is corrected afterwards.
  localparam int RECIP100  = 5243;
  localparam int SHIFT100  = 19;
  localparam int RECIP400  = 5243;
  localparam int SHIFT400  = 21;
  localparam int RECIP33   = 44542;
  localparam int SHIFT33   = 29;
  localparam int RECIP4    = 11484;
  localparam int SHIFT4    = 24;

  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam logic [LEN_W-1:0] MONTH_LEN [MONTHS] = '{
    5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
    5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd29
  };

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [LEN_W-1:0]   length;
  } solar_md_t;

endpackage

### sv/g2sh_if.sv
interface g2sh_in_if;
  import g2sh_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  greg_year;
  logic [MONTH_W-1:0] greg_month;
  logic [DAY_W-1:0]   greg_day;

  modport source (output valid, greg_year, greg_month, greg_day, input ready);
  modport sink   (input valid, greg_year, greg_month, greg_day, output ready);
endinterface

interface g2sh_out_if;
  import g2sh_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  solar_year;
  logic [MONTH_W-1:0] solar_month;
  logic [DAY_W-1:0]   solar_day;
  logic [LEN_W-1:0]   month_length;

  modport source (output valid, solar_year, solar_month, solar_day, month_length,
                  input ready);
  modport sink   (input valid, solar_year, solar_month, solar_day, month_length,
                  output ready);
endinterface

### sv/gregorian_to_solar_hijri_date_core.sv
// Gregorian to Solar Hijri date converter. Each input transaction carries a
// Gregorian year, month and day; each output transaction carries the Solar
// Hijri year, month, day and the length of that month from a fixed table in
// which Esfand always has 29 days (so a leap-year Esfand 30 reports a length
// of 29). The block takes one date per clock cycle while its input side is
// ready and delivers exactly one result for each, in order, from the last
// of the nine register stages of the arithmetic pipeline. Each stage holds
// its own valid bit and stalls only when it is full and the stage after it
// cannot take its contents, so gaps in the flow close up under
// back-pressure and nothing is lost or repeated.
// A month of zero is treated as January and a month above twelve as
// December. Days past the end of a month simply roll forward, and years
// before the start of the era give a negative year in twelve-bit two's
// complement. There is no configuration and no state beyond the pipeline.
`include "gregorian_to_solar_hijri_date_core_macros.svh"

module gregorian_to_solar_hijri_date_core (
  input  logic       clk,
  input  logic       rst,
  g2sh_in_if.sink    in_ch,
  g2sh_out_if.source out_ch
);
  import g2sh_pkg::*;

  localparam int STAGES = 9;

  // Pipeline control: v[k] marks stage k full, en[k] lets stage k load.
  logic [STAGES:1] v;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !v[STAGES] || out_ch.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_ch.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: clamp the month and form the parts of the day count. The
  // leap corrections use the following year once February has passed.
  logic [MONTH_W-1:0] gm_sat;
  logic [MONTH_W-1:0] ms_idx;
  logic [12:0]        gy2;
  logic [12:0]        t100;
  logic [12:0]        t400;
  logic [25:0]        p100;
  logic [25:0]        p400;

  always_comb begin
    if (in_ch.greg_month == '0) begin
      gm_sat = MONTH_W'(1);
    end else if (in_ch.greg_month > MONTH_W'(MONTHS)) begin
      gm_sat = MONTH_W'(MONTHS);
    end else begin
      gm_sat = in_ch.greg_month;
    end
    ms_idx = gm_sat - MONTH_W'(1);
    gy2    = 13'(in_ch.greg_year) + 13'(gm_sat > MONTH_W'(MONTH_FEB));
    t100   = gy2 + 13'd99;
    t400   = gy2 + 13'd399;
    p100   = 26'(t100) * 26'(RECIP100);
    p400   = 26'(t400) * 26'(RECIP400);
  end

  logic [DAYS_W-1:0] s1_yr365;
  logic [10:0]       s1_l4;
  logic [5:0]        s1_l100;
  logic [3:0]        s1_l400;
  logic [9:0]        s1_msd;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_yr365 <= DAYS_W'(in_ch.greg_year) * DAYS_W'(YEAR_DAYS);
      s1_l4    <= 11'((gy2 + 13'd3) >> 2);
      s1_l100  <= 6'(p100 >> SHIFT100);
      s1_l400  <= 4'(p400 >> SHIFT400);
      s1_msd   <= 10'(MONTH_START[ms_idx]) + 10'(in_ch.greg_day);
    end
  end

  // Stage 2: absolute day count.
  logic [DAYS_W-1:0] s2_days;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_days <= DAYS_W'(DAY_BASE) + s1_yr365 + DAYS_W'(s1_l4) - DAYS_W'(s1_l100)
               + DAYS_W'(s1_l400) + DAYS_W'(s1_msd);
    end
  end

  // Stage 3: estimate of the number of whole 33-year cycles, at most one low.
  logic [36:0]       p33;
  logic [7:0]        s3_q33;
  logic [DAYS_W-1:0] s3_days;

  assign p33 = 37'(s2_days) * 37'(RECIP33);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_q33  <= 8'(p33 >> SHIFT33);
      s3_days <= s2_days;
    end
  end

  // Stage 4: remainder against the estimate, less than twice the 33-year cycle length.
  logic [14:0] s4_rem;
  logic [7:0]  s4_q33;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_rem <= 15'(s3_days - DAYS_W'(s3_q33) * DAYS_W'(CYCLE33_DAYS));
      s4_q33 <= s3_q33;
    end
  end

  // Stage 5: correct the estimate when the remainder covers a whole cycle.
  logic [REM33_W-1:0] s5_rem;
  logic [7:0]         s5_q33;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (s4_rem >= 15'(CYCLE33_DAYS)) begin
        s5_rem <= REM33_W'(s4_rem - 15'(CYCLE33_DAYS));
        s5_q33 <= s4_q33 + 8'd1;
      end else begin
        s5_rem <= REM33_W'(s4_rem);
        s5_q33 <= s4_q33;
      end
    end
  end

  // Stage 6: number of 4-year groups; the year starts from the cycle count.
  logic [27:0]        p4;
  logic [3:0]         s6_q4;
  logic [REM33_W-1:0] s6_rem;
  logic [YEAR_W-1:0]  s6_jy;

  assign p4 = 28'(s5_rem) * 28'(RECIP4);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_q4  <= 4'(p4 >> SHIFT4);
      s6_rem <= s5_rem;
      s6_jy  <= YEAR_W'(YEAR_BASE) + YEAR_W'(YEAR_W'(s5_q33) * YEAR_W'(CYCLE33_YEARS));
    end
  end

  // Stage 7: day within the 4-year group.
  logic [REM4_W-1:0] s7_rem4;
  logic [YEAR_W-1:0] s7_jy;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_rem4 <= REM4_W'(s6_rem - REM33_W'(s6_q4) * REM33_W'(GROUP4_DAYS));
      s7_jy   <= s6_jy + YEAR_W'(s6_q4) * YEAR_W'(GROUP4_YEARS);
    end
  end

  // Stage 8: single years inside the group. The first year of a group is
  // the long one, so later years count from one day further on.
  logic [REM4_W-1:0] r1;
  logic [1:0]        ky;
  logic [DOY_W-1:0]  s8_remy;
  logic [YEAR_W-1:0] s8_jy;

  always_comb begin
    r1 = s7_rem4 - REM4_W'(1);
    if (r1 >= REM4_W'(3 * YEAR_DAYS)) begin
      ky = 2'd3;
    end else if (r1 >= REM4_W'(2 * YEAR_DAYS)) begin
      ky = 2'd2;
    end else begin
      ky = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      if (s7_rem4 > REM4_W'(YEAR_DAYS)) begin
        s8_remy <= DOY_W'(r1 - REM4_W'(ky) * REM4_W'(YEAR_DAYS));
        s8_jy   <= s7_jy + YEAR_W'(ky);
      end else begin
        s8_remy <= DOY_W'(s7_rem4);
        s8_jy   <= s7_jy;
      end
    end
  end

  // Stage 9: month and day, held in the output register.
  solar_md_t         md;
  solar_md_t         s9_md;
  logic [YEAR_W-1:0] s9_jy;

  g2sh_month_split u_month_split (
    .day_of_year (s8_remy),
    .md          (md)
  );

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_md <= md;
      s9_jy <= s8_jy;
    end
  end

  assign out_ch.valid        = v[STAGES];
  assign out_ch.solar_year   = s9_jy;
  assign out_ch.solar_month  = s9_md.month;
  assign out_ch.solar_day    = s9_md.day;
  assign out_ch.month_length = s9_md.length;

  `G2SH_ASSERT_NR(a_reset_empties, clk, $past(rst) |-> (v == '0), "pipeline not empty after reset")
  `G2SH_ASSERT(a_accept_fills, clk, rst, (in_ch.valid && in_ch.ready) |=> v[1], "accepted date lost at entry")
  `G2SH_ASSERT(a_cycle_rem, clk, rst, v[5] |-> (s5_rem < REM33_W'(CYCLE33_DAYS)), "cycle remainder out of range")
  `G2SH_ASSERT(a_year_rem, clk, rst, v[8] |-> (s8_remy <= DOY_W'(YEAR_DAYS)), "day of year out of range")

endmodule

### sv/g2sh_month_split.sv
// Splits a zero-based day of the Solar Hijri year into month, day and the
// fixed-table month length.
module g2sh_month_split (
  input  logic [g2sh_pkg::DOY_W-1:0] day_of_year,
  output g2sh_pkg::solar_md_t        md
);
  import g2sh_pkg::*;

  logic [DOY_W-1:0]   offset;
  logic               second_half;
  logic [2:0]         q;
  logic [DOY_W-1:0]   step;
  logic [DOY_W-1:0]   day_off;
  logic [MONTH_W-1:0] month;
  logic [MONTH_W-1:0] idx;

  always_comb begin
    second_half = (day_of_year >= DOY_W'(FIRST_HALF_DAYS));
    offset      = second_half ? (day_of_year - DOY_W'(FIRST_HALF_DAYS)) : day_of_year;
    step        = second_half ? DOY_W'(SHORT_MONTH) : DOY_W'(LONG_MONTH);
    // Independent threshold compares give the month within the half year.
    q = 3'd0;
    for (int k = 1; k < HALF_MONTHS; k++) begin
      if (offset >= DOY_W'(k * (second_half ? SHORT_MONTH : LONG_MONTH))) begin
        q = 3'(k);
      end
    end
    day_off = offset - DOY_W'(DOY_W'(q) * step);
    month   = (second_half ? MONTH_W'(HALF_MONTHS + 1) : MONTH_W'(1)) + MONTH_W'(q);
    if (month > MONTH_W'(MONTHS)) begin
      month = MONTH_W'(MONTHS);
    end
    idx       = month - MONTH_W'(1);
    md.month  = month;
    md.day    = DAY_W'(day_off) + DAY_W'(1);
    md.length = MONTH_LEN[idx];
  end

endmodule

### test/g2sh_date_checker.sv
// Watches both channels of the date converter, works out the expected Solar
// Hijri date for every accepted Gregorian date and compares each result
// transaction, in order, with the oldest date still awaited.
module g2sh_date_checker (
  input  logic clk,
  input  logic rst,
  g2sh_in_if   in_ch,
  g2sh_out_if  out_ch,
  output int   fail_count,
  output int   open_dates,
  output int   dates_checked
);
  import g2sh_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [LEN_W-1:0]   length;
  } solar_date_t;

  solar_date_t awaited_dates[$];
  solar_date_t want;

  initial begin
    fail_count    = 0;
    open_dates    = 0;
    dates_checked = 0;
  end

  // Day count from the Gregorian date, then split by 33-year cycles, 4-year
  // groups and single years; months out of range are clamped first.
  function automatic solar_date_t gregorian_to_solar(input logic [YEAR_W-1:0]  gy,
                                                     input logic [MONTH_W-1:0] gm_in,
                                                     input logic [DAY_W-1:0]   gd);
    int unsigned gm;
    int unsigned gy2;
    int unsigned day_count;
    int unsigned rem;
    int          jy;
    int unsigned jm;
    int unsigned jd;
    solar_date_t r;
    gm = gm_in;
    if (gm < 1) gm = 1;
    if (gm > MONTHS) gm = MONTHS;
    gy2 = (gm > MONTH_FEB) ? gy + 1 : gy;
    day_count = DAY_BASE + YEAR_DAYS * gy + (gy2 + 3) / 4 - (gy2 + 99) / 100
              + (gy2 + 399) / 400 + gd + MONTH_START[gm - 1];
    jy  = YEAR_BASE + CYCLE33_YEARS * int'(day_count / CYCLE33_DAYS);
    rem = day_count % CYCLE33_DAYS;
    jy  = jy + GROUP4_YEARS * int'(rem / GROUP4_DAYS);
    rem = rem % GROUP4_DAYS;
    if (rem > YEAR_DAYS) begin
      jy  = jy + int'((rem - 1) / YEAR_DAYS);
      rem = (rem - 1) % YEAR_DAYS;
    end
    if (rem < FIRST_HALF_DAYS) begin
      jm = 1 + rem / LONG_MONTH;
      jd = 1 + rem % LONG_MONTH;
    end else begin
      jm = 1 + HALF_MONTHS + (rem - FIRST_HALF_DAYS) / SHORT_MONTH;
      jd = 1 + (rem - FIRST_HALF_DAYS) % SHORT_MONTH;
    end
    if (jm > MONTHS) jm = MONTHS;
    r.year   = jy[YEAR_W-1:0];
    r.month  = jm[MONTH_W-1:0];
    r.day    = jd[DAY_W-1:0];
    r.length = MONTH_LEN[jm - 1];
    return r;
  endfunction

  // Every failure is printed on one line and counted.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        awaited_dates.push_back(gregorian_to_solar(in_ch.greg_year, in_ch.greg_month,
                                                   in_ch.greg_day));
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d with no date awaited",
                                    out_ch.solar_year, out_ch.solar_month,
                                    out_ch.solar_day));
        end else begin
          want = awaited_dates.pop_front();
          dates_checked++;
          if (out_ch.solar_year !== want.year)
            report_mismatch($sformatf("solar_year %0d, expected %0d",
                                      out_ch.solar_year, want.year));
          if (out_ch.solar_month !== want.month)
            report_mismatch($sformatf("solar_month %0d, expected %0d",
                                      out_ch.solar_month, want.month));
          if (out_ch.solar_day !== want.day)
            report_mismatch($sformatf("solar_day %0d, expected %0d",
                                      out_ch.solar_day, want.day));
          if (out_ch.month_length !== want.length)
            report_mismatch($sformatf("month_length %0d, expected %0d",
                                      out_ch.month_length, want.length));
        end
      end
      open_dates <= awaited_dates.size();
    end
  end

endmodule

### test/tb_top.sv
// Top level of the date converter testbench. It generates the clock and the
// single reset, drives Gregorian dates into the converter, applies
// back-pressure on the result side and gives the final verdict. All
// prediction and comparison lives in the checker instantiated beside the
// block.
module tb_top;
  import g2sh_pkg::*;

  localparam int RANDOM_DATES = 800;
  localparam int HOLD_CYCLES  = 60;
  // Nine register stages in the converter; the drain wait allows for more.
  localparam int DRAIN_CYCLES = 30;

  logic clk;
  logic rst;
  int   fail_count;
  int   open_dates;
  int   dates_checked;
  int   dates_sent;
  bit   quiet;
  bit   hold_request;

  g2sh_in_if  in_ch ();
  g2sh_out_if out_ch ();

  gregorian_to_solar_hijri_date_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  g2sh_date_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .open_dates    (open_dates),
    .dates_checked (dates_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A hard limit on the whole run, far beyond what a correct block needs
  // even with every stall and gap at its worst.
  initial begin
    repeat (200000) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Offers one date and holds it until the converter accepts it. Valid is
  // only lowered for an idle gap, so a back-to-back transaction never sees
  // it dropped and raised again within one time step.
  task automatic send_date(input logic [YEAR_W-1:0]  year,
                           input logic [MONTH_W-1:0] month,
                           input logic [DAY_W-1:0]   day);
    if (!quiet && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 30);
    end
    in_ch.valid      <= 1'b1;
    in_ch.greg_year  <= year;
    in_ch.greg_month <= month;
    in_ch.greg_day   <= day;
    do @(posedge clk); while (!in_ch.ready);
    dates_sent++;
    @(negedge clk);
  endtask

  // Picks a day that exists in the given month, ignoring leap years so that
  // it never gives the twenty-ninth of February.
  function automatic logic [DAY_W-1:0] plausible_day(input logic [MONTH_W-1:0] month);
    int days_in_month;
    case (month)
      4, 6, 9, 11: days_in_month = SHORT_MONTH;
      MONTH_FEB:   days_in_month = 28;
      default:     days_in_month = LONG_MONTH;
    endcase
    return DAY_W'($urandom_range(days_in_month, 1));
  endfunction

  // The result side. Ready drops at random about eight times in a hundred,
  // except during the quiet stretch. When the sender asks for it, ready is
  // held low for a long stretch counted here, so the pipeline fills up and
  // the input side stalls while dates keep being offered.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    rst              <= 1'b1;
    quiet            = 1'b0;
    hold_request     = 1'b0;
    dates_sent       = 0;
    in_ch.valid      <= 1'b0;
    in_ch.greg_year  <= '0;
    in_ch.greg_month <= '0;
    in_ch.greg_day   <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed dates. The extremes of every field come first: year zero and
    // the largest year, then a year before the era, which must come back as
    // a negative year in two's complement.
    send_date(12'd0, 4'd1, 5'd1);
    send_date(12'd4095, 4'd12, 5'd31);
    send_date(12'd500, 4'd6, 5'd15);
    send_date(12'd622, 4'd3, 5'd22);
    // Leap-day handling across the century rules.
    send_date(12'd2000, 4'd2, 5'd29);
    send_date(12'd2000, 4'd3, 5'd1);
    send_date(12'd1900, 4'd3, 5'd1);
    send_date(12'd2100, 4'd2, 5'd28);
    // New Year's Day, and the thirtieth of Esfand in a leap year, for which
    // the month length still reads 29.
    send_date(12'd2024, 4'd3, 5'd20);
    send_date(12'd2025, 4'd3, 5'd20);
    send_date(12'd2021, 4'd3, 5'd20);
    // Months of zero and above twelve are clamped to January and December.
    send_date(12'd2023, 4'd0, 5'd5);
    send_date(12'd2023, 4'd13, 5'd5);
    send_date(12'd4000, 4'd15, 5'd31);
    // A day of zero and a day past the end of February simply roll over.
    send_date(12'd2023, 4'd5, 5'd0);
    send_date(12'd2023, 4'd2, 5'd31);
    // Every month once.
    for (int m = 1; m <= MONTHS; m++) begin
      month = MONTH_W'(m);
      send_date(12'd2023, month, plausible_day(month));
    end

    // Random dates: most are well formed within the usual range of years,
    // the rest use every value the fields can hold.
    for (int i = 0; i < RANDOM_DATES; i++) begin
      if (i == 200) hold_request = 1'b1;
      quiet = (i >= 300 && i < 450);
      if (i == 500) begin
        // Let the pipeline empty completely before carrying on.
        in_ch.valid <= 1'b0;
        wait (open_dates == 0);
        @(negedge clk);
      end
      if ($urandom_range(99) < 90) begin
        year  = YEAR_W'($urandom_range(4095, 1000));
        month = MONTH_W'($urandom_range(MONTHS, 1));
        day   = plausible_day(month);
      end else begin
        year  = YEAR_W'($urandom);
        month = MONTH_W'($urandom);
        day   = DAY_W'($urandom);
      end
      send_date(year, month, day);
    end
    in_ch.valid <= 1'b0;
    quiet = 1'b0;

    wait (open_dates == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d dates and checked %0d results over field extremes, clamped months,",
             dates_sent, dates_checked);
    $display("rolled-over days, early years, leap-year Esfand, a long stall and a drain.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### gregorian_to_solar_hijri_date_core.f
+incdir+sv
sv/g2sh_pkg.sv
sv/g2sh_if.sv
sv/g2sh_month_split.sv
sv/gregorian_to_solar_hijri_date_core.sv
test/g2sh_date_checker.sv
test/tb_top.sv
